/* rtl/core/hsvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared widths, constants and types for the HSV to RGB color converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int HUE_BITS     = 16;
  localparam int CHANNEL_BITS = 8;

  // Channel code that stands for 1.0
  localparam int CH_MAX = (1 << CHANNEL_BITS) - 1;

  // Hue weight k ranges over 0 .. 2^HUE_BITS inclusive
  localparam int K_W    = HUE_BITS + 1;
  localparam int SCL_W  = HUE_BITS + 3;           // 6 * hue
  localparam int PROD_W = CHANNEL_BITS + K_W;     // sat * k
  localparam int NUM_W  = CHANNEL_BITS + HUE_BITS; // M * D - sat * k
  localparam int P_W    = CHANNEL_BITS + NUM_W;   // val * num
  localparam int X_W    = 2 * CHANNEL_BITS;       // val * num / D
  localparam int EST_W  = 3 * CHANNEL_BITS + 1;   // x * (M + 2)

  localparam logic [NUM_W-1:0] DEN      = NUM_W'(CH_MAX) << HUE_BITS;
  localparam logic [K_W-1:0]   K_FULL   = K_W'(1) << HUE_BITS;
  localparam logic [K_W-1:0]   K_ZERO   = '0;
  localparam logic [X_W-1:0]   X_CHMAX  = X_W'(CH_MAX);
  localparam logic [EST_W-1:0] RECIP    = EST_W'(CH_MAX + 2);

  // Cycles from an accepted start to the result strobe
  localparam int LATENCY = 5;

  // Six color sectors of the hue circle
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // Per-channel hue weights plus the pixel's saturation and value
  typedef struct packed {
    logic [K_W-1:0]          kr;
    logic [K_W-1:0]          kg;
    logic [K_W-1:0]          kb;
    logic [CHANNEL_BITS-1:0] sat;
    logic [CHANNEL_BITS-1:0] val;
  } weights_t;

endpackage

/* rtl/core/hsvrgb_sector.sv */
// ----------------------------------------------------------------------------
// hsvrgb_sector
// Stage 1: split hue into sector and fraction, pick per-channel weights.
// ----------------------------------------------------------------------------
module hsvrgb_sector (
  input  logic                                 clk,
  input  logic [hsvrgb_pkg::HUE_BITS-1:0]      hue_i,
  input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  sat_i,
  input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  val_i,
  output hsvrgb_pkg::weights_t                 wgt_o
);

  logic [hsvrgb_pkg::SCL_W-1:0]    scaled;
  hsvrgb_pkg::sector_t             sector;
  logic [hsvrgb_pkg::K_W-1:0]      frac;
  logic [hsvrgb_pkg::K_W-1:0]      rfrac;
  hsvrgb_pkg::weights_t            wgt_nxt;
  hsvrgb_pkg::weights_t            wgt_r;

  // 6 * hue as two shifted adds
  assign scaled = (hsvrgb_pkg::SCL_W'(hue_i) << 2) + (hsvrgb_pkg::SCL_W'(hue_i) << 1);
  assign sector = hsvrgb_pkg::sector_t'(scaled[hsvrgb_pkg::SCL_W-1:hsvrgb_pkg::HUE_BITS]);
  assign frac   = hsvrgb_pkg::K_W'(scaled[hsvrgb_pkg::HUE_BITS-1:0]);
  assign rfrac  = hsvrgb_pkg::K_FULL - frac;

  always_comb begin
    wgt_nxt.sat = sat_i;
    wgt_nxt.val = val_i;
    unique case (sector)
      hsvrgb_pkg::SEC_RED_YEL: begin
        wgt_nxt.kr = hsvrgb_pkg::K_ZERO;
        wgt_nxt.kg = rfrac;
        wgt_nxt.kb = hsvrgb_pkg::K_FULL;
      end
      hsvrgb_pkg::SEC_YEL_GRN: begin
        wgt_nxt.kr = frac;
        wgt_nxt.kg = hsvrgb_pkg::K_ZERO;
        wgt_nxt.kb = hsvrgb_pkg::K_FULL;
      end
      hsvrgb_pkg::SEC_GRN_CYN: begin
        wgt_nxt.kr = hsvrgb_pkg::K_FULL;
        wgt_nxt.kg = hsvrgb_pkg::K_ZERO;
        wgt_nxt.kb = rfrac;
      end
      hsvrgb_pkg::SEC_CYN_BLU: begin
        wgt_nxt.kr = hsvrgb_pkg::K_FULL;
        wgt_nxt.kg = frac;
        wgt_nxt.kb = hsvrgb_pkg::K_ZERO;
      end
      hsvrgb_pkg::SEC_BLU_MAG: begin
        wgt_nxt.kr = rfrac;
        wgt_nxt.kg = hsvrgb_pkg::K_FULL;
        wgt_nxt.kb = hsvrgb_pkg::K_ZERO;
      end
      default: begin
        // Magenta sector; hue below a full turn never goes past it
        wgt_nxt.kr = hsvrgb_pkg::K_ZERO;
        wgt_nxt.kg = hsvrgb_pkg::K_FULL;
        wgt_nxt.kb = frac;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    wgt_r <= wgt_nxt;
  end

  assign wgt_o = wgt_r;

endmodule

/* rtl/core/hsvrgb_divm.sv */
// ----------------------------------------------------------------------------
// hsvrgb_divm
// Stages 4-5: floor divide by the full-scale channel code M = 2^C - 1.
// ----------------------------------------------------------------------------
module hsvrgb_divm (
  input  logic                                 clk,
  input  logic [hsvrgb_pkg::X_W-1:0]           x_i,
  output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  q_o
);

  localparam int CB = hsvrgb_pkg::CHANNEL_BITS;

  logic [hsvrgb_pkg::EST_W-1:0] scaled;
  logic [CB-1:0]                est_nxt;
  logic [CB-1:0]                est_r;
  logic [hsvrgb_pkg::X_W-1:0]   x_r;
  logic [hsvrgb_pkg::X_W-1:0]   back;
  logic [hsvrgb_pkg::X_W-1:0]   rem;
  logic [CB-1:0]                q_nxt;
  logic [CB-1:0]                q_r;

  // Reciprocal estimate x * (M + 2) / 2^2C: exact or one short
  assign scaled  = hsvrgb_pkg::EST_W'(x_i) * hsvrgb_pkg::RECIP;
  assign est_nxt = scaled[2*CB +: CB];

  always_ff @(posedge clk) begin
    est_r <= est_nxt;
    x_r   <= x_i;
  end

  // est * M as shift and subtract, then bump when the remainder reaches M
  assign back  = (hsvrgb_pkg::X_W'(est_r) << CB) - hsvrgb_pkg::X_W'(est_r);
  assign rem   = x_r - back;
  assign q_nxt = (rem >= hsvrgb_pkg::X_CHMAX) ? est_r + CB'(1) : est_r;

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

/* rtl/core/hsvrgb_lane.sv */
// ----------------------------------------------------------------------------
// hsvrgb_lane
// Stages 2-5 of one color channel: val * (M*D - sat*k) / (M*D), floored.
// ----------------------------------------------------------------------------
module hsvrgb_lane (
  input  logic                                 clk,
  input  logic [hsvrgb_pkg::K_W-1:0]           k_i,
  input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  sat_i,
  input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  val_i,
  output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  code_o
);

  logic [hsvrgb_pkg::PROD_W-1:0]       prod;
  logic [hsvrgb_pkg::NUM_W-1:0]        num_nxt;
  logic [hsvrgb_pkg::NUM_W-1:0]        num_r;
  logic [hsvrgb_pkg::CHANNEL_BITS-1:0] val_r;
  logic [hsvrgb_pkg::P_W-1:0]          pix;
  logic [hsvrgb_pkg::X_W-1:0]          x_nxt;
  logic [hsvrgb_pkg::X_W-1:0]          x_r;

  // Stage 2: sat * k never exceeds M * D, so the numerator fits NUM_W
  assign prod    = hsvrgb_pkg::PROD_W'(sat_i) * hsvrgb_pkg::PROD_W'(k_i);
  assign num_nxt = hsvrgb_pkg::DEN - prod[hsvrgb_pkg::NUM_W-1:0];

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    val_r <= val_i;
  end

  // Stage 3: scale by val and drop the hue denominator
  assign pix   = hsvrgb_pkg::P_W'(val_r) * hsvrgb_pkg::P_W'(num_r);
  assign x_nxt = pix[hsvrgb_pkg::HUE_BITS +: hsvrgb_pkg::X_W];

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  hsvrgb_divm u_divm (
    .clk (clk),
    .x_i (x_r),
    .q_o (code_o)
  );

endmodule

/* rtl/core/hsv_to_rgb.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb
// Six-sector HSV to 8-bit RGB converter, exact floor(255 * intensity).
// ----------------------------------------------------------------------------
// Result: an accepted start yields one out_valid strobe at the end of the pipeline.
// Throughput: one pixel per cycle; the five-stage pipeline never stalls and
//   the receiver cannot hold results off, so busy stays low after reset.
// Reset: synchronous, active low; drops every item in flight and holds busy
//   high up to the first cycle after rst_n rises.
// ----------------------------------------------------------------------------
module hsv_to_rgb (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [hsvrgb_pkg::HUE_BITS-1:0]      in_hue,
  input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  in_sat,
  input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  in_val,
  output logic                                 out_valid,
  output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  out_red,
  output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  out_green,
  output logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  out_blue
);

  logic                              busy_r;
  logic                              busy_nxt;
  logic [hsvrgb_pkg::LATENCY-1:0]    vld_r;
  logic [hsvrgb_pkg::LATENCY-1:0]    vld_nxt;
  logic                              take;
  hsvrgb_pkg::weights_t              wgt;

  // A transfer on the input side: start while not busy
  assign take = start && !busy_r;

  // Hold busy through reset, release it once reset is gone
  assign busy_nxt = 1'b0;

  // Advance valid bits alongside the data stages, one bit per stage
  assign vld_nxt = {vld_r[hsvrgb_pkg::LATENCY-2:0], take};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
  end

  // Stage 1: sector split and weight selection
  hsvrgb_sector u_sector (
    .clk   (clk),
    .hue_i (in_hue),
    .sat_i (in_sat),
    .val_i (in_val),
    .wgt_o (wgt)
  );

  // Stages 2-5: one arithmetic lane per color channel
  hsvrgb_lane u_lane_red (
    .clk    (clk),
    .k_i    (wgt.kr),
    .sat_i  (wgt.sat),
    .val_i  (wgt.val),
    .code_o (out_red)
  );

  hsvrgb_lane u_lane_green (
    .clk    (clk),
    .k_i    (wgt.kg),
    .sat_i  (wgt.sat),
    .val_i  (wgt.val),
    .code_o (out_green)
  );

  hsvrgb_lane u_lane_blue (
    .clk    (clk),
    .k_i    (wgt.kb),
    .sat_i  (wgt.sat),
    .val_i  (wgt.val),
    .code_o (out_blue)
  );

  // The last valid bit marks the single cycle a result transfer is shown
  assign out_valid = vld_r[hsvrgb_pkg::LATENCY-1];
  assign busy      = busy_r;

endmodule

/* rtl/core/hsvrgb_checker.sv */
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks for hsv_to_rgb, attached by bind.
// ----------------------------------------------------------------------------
module hsvrgb_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  in_sat,
  input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  in_val,
  input  logic                                 out_valid,
  input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  out_red,
  input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  out_green,
  input  logic [hsvrgb_pkg::CHANNEL_BITS-1:0]  out_blue
);

  // Every input transfer is followed by a result strobe
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(hsvrgb_pkg::LATENCY) out_valid)
    else $error("accepted pixel did not produce a result");

  // No result without a matching earlier input transfer
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, hsvrgb_pkg::LATENCY))
    else $error("result strobe without a matching input");

  // Zero saturation gives gray at the pixel's value
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_sat, hsvrgb_pkg::LATENCY) == '0)) |->
      (out_red == $past(in_val, hsvrgb_pkg::LATENCY)) &&
      (out_green == $past(in_val, hsvrgb_pkg::LATENCY)) &&
      (out_blue == $past(in_val, hsvrgb_pkg::LATENCY)))
    else $error("zero saturation did not give gray");

  // No channel exceeds the value
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= $past(in_val, hsvrgb_pkg::LATENCY)) &&
      (out_green <= $past(in_val, hsvrgb_pkg::LATENCY)) &&
      (out_blue <= $past(in_val, hsvrgb_pkg::LATENCY)))
    else $error("channel above value");

  // Out of reset the converter takes a pixel every cycle
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |-> ##1 !busy)
    else $error("busy raised outside reset");

endmodule

bind hsv_to_rgb hsvrgb_checker u_hsvrgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_sat    (in_sat),
  .in_val    (in_val),
  .out_valid (out_valid),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);
